// ===== rtl/core/pim_pkg.sv =====
// ----------------------------------------------------------------------------
// pim_pkg
// Shared types and codes for the priority inheritance mutex: state machine
// states, status codes, the scan token and the per-cell control bundle.
// ----------------------------------------------------------------------------
package pim_pkg;

   localparam int ID_W   = 6;   // task id width
   localparam int PRIO_W = 8;   // priority width
   localparam int IDX_W  = 6;   // holds any waiter index (up to 64 waiters)
   localparam int CNT_W  = 7;   // holds any waiter count (up to 64)

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMPACT
   } state_type;

   typedef enum logic [2:0] {
      STAT_ACQUIRED  = 3'd0,
      STAT_BLOCKED   = 3'd1,
      STAT_RELEASED  = 3'd2,
      STAT_HANDED    = 3'd3,
      STAT_NOT_OWNER = 3'd4,
      STAT_FULL      = 3'd5
   } status_type;

   // running best waiter, handed from cell to cell
   typedef struct packed {
      logic              valid;
      logic [PRIO_W-1:0] prio;
      logic [ID_W-1:0]   id;
      logic [IDX_W-1:0]  idx;
   } tok_type;

   typedef struct packed {
      logic             append;
      logic             compact;
      logic [CNT_W-1:0] count;
      logic [IDX_W-1:0] best;
   } cell_ctrl_type;

endpackage

// ===== rtl/core/priority_inheritance_mutex.sv =====
// ----------------------------------------------------------------------------
// priority_inheritance_mutex
// Hardware mutex with priority inheritance and a compacting waiter list.
// ----------------------------------------------------------------------------
// Usage:
//  A transaction is taken on the rising edge where start is high and busy is
//  low; req_func selects lock (0) or unlock (1), with the requester's id and
//  priority. Exactly one response follows per transaction, shown for one
//  cycle with rsp_strobe high; the receiver cannot stall it.
//  Lock and any unlock that does not hand over ownership: response in the
//  next cycle, busy stays low, so one transaction per cycle.
//  Unlock that wakes a waiter: the max-priority token walks the row of
//  MAX_WAITERS cells one cell per cycle, then the compact state shrinks the
//  list. busy is high through the scan and compact states, and the response
//  is registered at the end of the compact state.
//  rsp_owner_* reflect the mutex state after the latest transaction.
//  Reset frees the mutex and empties the waiter list; no clearing pass.
// ----------------------------------------------------------------------------
module priority_inheritance_mutex
   import pim_pkg::*;
#(
   parameter int MAX_WAITERS = 16,
   parameter int MAX_TASKS   = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_func,
   input  logic [ID_W-1:0]   req_task_id,
   input  logic [PRIO_W-1:0] req_task_priority,
   output logic              rsp_strobe,
   output logic [2:0]        rsp_status,
   output logic [PRIO_W-1:0] rsp_restored_priority,
   output logic              rsp_woken_valid,
   output logic [ID_W-1:0]   rsp_woken_id,
   output logic              rsp_owner_valid,
   output logic [ID_W-1:0]   rsp_owner_id,
   output logic [PRIO_W-1:0] rsp_owner_priority
);

   localparam int CW = $clog2(MAX_WAITERS + 1);
   localparam int IW = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
   localparam logic [CW-1:0] FULL_CNT  = CW'(MAX_WAITERS);
   localparam logic [IW-1:0] SCAN_LAST = IW'(MAX_WAITERS - 1);

   state_type         state_ff, state_in;
   logic [IW-1:0]     scan_cnt_ff, scan_cnt_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              held_ff, held_in;
   logic [ID_W-1:0]   holder_ff, holder_in;
   logic [PRIO_W-1:0] saved_ff, saved_in;
   logic [PRIO_W-1:0] boost_ff, boost_in;

   logic              strobe_ff, strobe_in;
   status_type        status_ff, status_in;
   logic [PRIO_W-1:0] restored_ff, restored_in;
   logic              wvalid_ff, wvalid_in;
   logic [ID_W-1:0]   wid_ff, wid_in;

   logic              accept;
   logic [ID_W-1:0]   id_red;
   logic              is_owner;
   logic              handover;
   cell_ctrl_type     ctrl;

   tok_type           tok [MAX_WAITERS+1];
   logic [ID_W-1:0]   ent_id   [MAX_WAITERS];
   logic [PRIO_W-1:0] ent_prio [MAX_WAITERS];

   // task id modulo MAX_TASKS by restoring subtraction
   always_comb begin
      int unsigned rem;
      rem = int'(req_task_id);
      for (int k = ID_W - 1; k >= 0; k--) begin
         if ((MAX_TASKS << k) <= rem) begin
            rem = rem - (MAX_TASKS << k);
         end
      end
      id_red = rem[ID_W-1:0];
   end

   assign accept   = start && !busy;
   assign busy     = state_ff != ST_IDLE;
   assign is_owner = held_ff && holder_ff == id_red;
   assign handover = accept && req_func && is_owner && count_ff != '0;

   // waiter cell row
   assign tok[0] = '0;

   assign ctrl.append  = accept && !req_func && held_ff && count_ff != FULL_CNT;
   assign ctrl.compact = state_ff == ST_COMPACT;
   assign ctrl.count   = CNT_W'(count_ff);
   assign ctrl.best    = tok[MAX_WAITERS].idx;

   for (genvar i = 0; i < MAX_WAITERS; i++) begin : g_cell
      logic [ID_W-1:0]   nbr_id;
      logic [PRIO_W-1:0] nbr_prio;
      if (i == MAX_WAITERS - 1) begin : g_last
         assign nbr_id   = '0;
         assign nbr_prio = '0;
      end else begin : g_mid
         assign nbr_id   = ent_id[i+1];
         assign nbr_prio = ent_prio[i+1];
      end
      pim_cell #(
         .INDEX (i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .wr_id    (id_red),
         .wr_prio  (req_task_priority),
         .nbr_id   (nbr_id),
         .nbr_prio (nbr_prio),
         .tok_in   (tok[i]),
         .tok_out  (tok[i+1]),
         .ent_id   (ent_id[i]),
         .ent_prio (ent_prio[i])
      );
   end

   // next state
   always_comb begin
      state_in    = state_ff;
      scan_cnt_in = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (handover) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            scan_cnt_in = scan_cnt_ff + 1'b1;
            if (scan_cnt_ff == SCAN_LAST) begin
               state_in = ST_COMPACT;
            end
         end
         ST_COMPACT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // mutex state and response
   always_comb begin
      count_in    = count_ff;
      held_in     = held_ff;
      holder_in   = holder_ff;
      saved_in    = saved_ff;
      boost_in    = boost_ff;
      strobe_in   = 1'b0;
      status_in   = status_ff;
      restored_in = '0;
      wvalid_in   = 1'b0;
      wid_in      = '0;

      if (state_ff == ST_COMPACT) begin
         holder_in   = tok[MAX_WAITERS].id;
         saved_in    = tok[MAX_WAITERS].prio;
         boost_in    = tok[MAX_WAITERS].prio;
         count_in    = count_ff - 1'b1;
         strobe_in   = 1'b1;
         status_in   = STAT_HANDED;
         restored_in = saved_ff;
         wvalid_in   = 1'b1;
         wid_in      = tok[MAX_WAITERS].id;
      end else if (accept) begin
         if (!req_func) begin
            strobe_in = 1'b1;
            if (!held_ff) begin
               held_in   = 1'b1;
               holder_in = id_red;
               saved_in  = req_task_priority;
               boost_in  = req_task_priority;
               status_in = STAT_ACQUIRED;
            end else if (count_ff == FULL_CNT) begin
               status_in = STAT_FULL;
            end else begin
               if (req_task_priority > boost_ff) begin
                  boost_in = req_task_priority;
               end
               count_in  = count_ff + 1'b1;
               status_in = STAT_BLOCKED;
            end
         end else if (!is_owner) begin
            strobe_in = 1'b1;
            status_in = STAT_NOT_OWNER;
         end else if (count_ff == '0) begin
            strobe_in   = 1'b1;
            status_in   = STAT_RELEASED;
            restored_in = saved_ff;
            held_in     = 1'b0;
            holder_in   = '0;
            saved_in    = '0;
            boost_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         scan_cnt_ff <= '0;
         count_ff    <= '0;
         held_ff     <= 1'b0;
         holder_ff   <= '0;
         saved_ff    <= '0;
         boost_ff    <= '0;
         strobe_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         scan_cnt_ff <= scan_cnt_in;
         count_ff    <= count_in;
         held_ff     <= held_in;
         holder_ff   <= holder_in;
         saved_ff    <= saved_in;
         boost_ff    <= boost_in;
         strobe_ff   <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff   <= status_in;
      restored_ff <= restored_in;
      wvalid_ff   <= wvalid_in;
      wid_ff      <= wid_in;
   end

   assign rsp_strobe            = strobe_ff;
   assign rsp_status            = status_ff;
   assign rsp_restored_priority = restored_ff;
   assign rsp_woken_valid       = wvalid_ff;
   assign rsp_woken_id          = wid_ff;
   assign rsp_owner_valid       = held_ff;
   assign rsp_owner_id          = held_ff ? holder_ff : '0;
   assign rsp_owner_priority    = held_ff ? boost_ff : '0;

`ifndef NO_ASSERTIONS
   a_tail_valid: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_COMPACT |-> tok[MAX_WAITERS].valid && held_ff)
      else $error("compact without a valid best waiter");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("waiter count beyond capacity");

   a_strobe_src: assert property (@(posedge clock) disable iff (reset)
      strobe_in |-> accept || state_ff == ST_COMPACT)
      else $error("response without a transaction");

   a_handed: assert property (@(posedge clock) disable iff (reset)
      strobe_ff && status_ff == STAT_HANDED |-> wvalid_ff && held_ff
         && holder_ff == wid_ff)
      else $error("handover response inconsistent with owner");

   a_scan_len: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN && scan_cnt_ff == SCAN_LAST |=> state_ff == ST_COMPACT)
      else $error("scan did not end in compaction");
`endif

endmodule

// ===== rtl/core/pim_cell.sv =====
// ----------------------------------------------------------------------------
// pim_cell
// One waiter slot. Holds a waiter id and priority written on append, folds
// itself into the max-priority token passing down the chain, and shifts in
// its upper neighbor when the list is compacted.
// ----------------------------------------------------------------------------
module pim_cell
   import pim_pkg::*;
#(
   parameter int INDEX = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  cell_ctrl_type     ctrl,
   input  logic [ID_W-1:0]   wr_id,
   input  logic [PRIO_W-1:0] wr_prio,
   input  logic [ID_W-1:0]   nbr_id,
   input  logic [PRIO_W-1:0] nbr_prio,
   input  tok_type           tok_in,
   output tok_type           tok_out,
   output logic [ID_W-1:0]   ent_id,
   output logic [PRIO_W-1:0] ent_prio
);

   localparam logic [CNT_W-1:0] IDX_C  = CNT_W'(INDEX);
   localparam logic [CNT_W-1:0] IDX_N  = CNT_W'(INDEX + 1);

   logic [ID_W-1:0]   id_ff, id_in;
   logic [PRIO_W-1:0] prio_ff, prio_in;
   tok_type           tok_ff, tok_in_next;
   logic              active;

   assign active = IDX_C < ctrl.count;

   // strict greater-than keeps the earliest waiter on ties
   always_comb begin
      tok_in_next = tok_in;
      if (active && (!tok_in.valid || prio_ff > tok_in.prio)) begin
         tok_in_next.valid = 1'b1;
         tok_in_next.prio  = prio_ff;
         tok_in_next.id    = id_ff;
         tok_in_next.idx   = IDX_W'(INDEX);
      end
   end

   always_comb begin
      id_in   = id_ff;
      prio_in = prio_ff;
      if (ctrl.append && ctrl.count == IDX_C) begin
         id_in   = wr_id;
         prio_in = wr_prio;
      end else if (ctrl.compact && {1'b0, ctrl.best} <= IDX_C && IDX_N < ctrl.count) begin
         id_in   = nbr_id;
         prio_in = nbr_prio;
      end
   end

   always_ff @(posedge clock) begin
      id_ff   <= id_in;
      prio_ff <= prio_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_next;
      end
   end

   assign tok_out  = tok_ff;
   assign ent_id   = id_ff;
   assign ent_prio = prio_ff;

endmodule
